// ===== sv/packed_bit_array_range_fill_macros.svh =====
// ---------------------------------------------------------------------------
// packed_bit_array_range_fill assertion macros
// shared property forms for the checker, clocked on clock, held off in reset
// ---------------------------------------------------------------------------
`ifndef PACKED_BIT_ARRAY_RANGE_FILL_MACROS_SVH
`define PACKED_BIT_ARRAY_RANGE_FILL_MACROS_SVH

// same-cycle implication
`define PBAF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBAF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pbaf_pkg.sv =====
// ---------------------------------------------------------------------------
// pbaf_pkg
// opcodes, field widths and the command and status bundles of the flag store
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbaf_pkg;

   // field widths
   localparam int OpBits      = 3;
   localparam int IdxBits     = 13;
   localparam int CntBits     = 14;
   localparam int DivBits     = 15;
   localparam int ReqDataBits = 32;
   localparam int RspDataBits = 16;

   // opcodes
   localparam logic [OpBits-1:0] OP_GET    = 3'd0;
   localparam logic [OpBits-1:0] OP_SET    = 3'd1;
   localparam logic [OpBits-1:0] OP_FILL   = 3'd2;
   localparam logic [OpBits-1:0] OP_RESIZE = 3'd3;
   localparam logic [OpBits-1:0] OP_CLEAR  = 3'd4;

   // divider operand select
   localparam logic [1:0] DIV_IDX = 2'd0;
   localparam logic [1:0] DIV_OLD = 2'd1;
   localparam logic [1:0] DIV_NEW = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic [1:0] div_sel;
      logic       seek_load;
      logic       seek_one;
      logic       base_load;
      logic       limit_load;
      logic       mem_rd;
      logic       wr_fill;
      logic       wr_grow;
      logic       cap_bit;
      logic       set_err;
      logic       size_load;
      logic       size_clear;
      logic       finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OpBits-1:0] opcode;
      logic              idx_out;
      logic              fill_out;
      logic              resize_out;
      logic              fill_empty;
      logic              mask_full;
      logic              last_word;
      logic              grow_done;
      logic              rsp_free;
   } status_type;

endpackage

// ===== sv/pbaf_ram.sv =====
// ---------------------------------------------------------------------------
// pbaf_ram
// generic single-port word memory with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbaf_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 256,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [WIDTH-1:0]     wr_data,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read on one port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pbaf_div.sv =====
// ---------------------------------------------------------------------------
// pbaf_div
// two-stage split of a bit position into word number and bit offset
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbaf_div #(
   parameter int WORD_BITS = 32,
   parameter int QUOT_BITS = $clog2((1 << pbaf_pkg::DivBits) / WORD_BITS),
   parameter int REM_BITS  = $clog2(WORD_BITS)
) (
   input  logic                         clock,
   input  logic [pbaf_pkg::DivBits-1:0] dividend,
   output logic [QUOT_BITS-1:0]         quot,
   output logic [REM_BITS-1:0]          rem
);

   localparam int Dw       = pbaf_pkg::DivBits;
   localparam int Recip    = (1 << Dw) / WORD_BITS;
   localparam int RecBits  = $clog2(Recip + 1);
   localparam int ProdBits = Dw + RecBits;

   logic [Dw-1:0]        x_ff, x_in;
   logic [ProdBits-1:0]  prod_ff, prod_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [QUOT_BITS-1:0] q_est;
   logic [Dw-1:0]        back;
   logic [Dw-1:0]        diff;

   // stage one: estimate by reciprocal, low by at most one
   always_comb begin
      x_in    = dividend;
      prod_in = ProdBits'(dividend) * ProdBits'(Recip);
   end

   // stage two: remainder and one correction step
   always_comb begin
      q_est = QUOT_BITS'(prod_ff[ProdBits-1:Dw]);
      back  = Dw'(Dw'(q_est) * Dw'(WORD_BITS));
      diff  = x_ff - back;
      if (diff >= Dw'(WORD_BITS)) begin
         quot_in = q_est + QUOT_BITS'(1);
         rem_in  = REM_BITS'(diff - Dw'(WORD_BITS));
      end else begin
         quot_in = q_est;
         rem_in  = REM_BITS'(diff);
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ===== sv/pbaf_dpath.sv =====
// ---------------------------------------------------------------------------
// pbaf_dpath
// item registers, size register, word walker, word memory and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbaf_dpath #(
   parameter int WORD_BITS  = 32,
   parameter int WORD_COUNT = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pbaf_pkg::cmd_type                cmd,
   output pbaf_pkg::status_type             status,
   input  logic [pbaf_pkg::ReqDataBits-1:0] req_tdata,
   input  logic [pbaf_pkg::OpBits-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pbaf_pkg::RspDataBits-1:0] rsp_tdata,
   output logic                             rsp_tuser
);

   localparam int IdxW    = pbaf_pkg::IdxBits;
   localparam int CntW    = pbaf_pkg::CntBits;
   localparam int Dw      = pbaf_pkg::DivBits;
   localparam int CntLo   = IdxW;
   localparam int FlagPos = IdxW + CntW;
   localparam int AW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int QW      = $clog2((1 << Dw) / WORD_BITS);
   localparam int OW      = $clog2(WORD_BITS);
   localparam int CapBits = WORD_BITS * WORD_COUNT;

   // item registers
   logic [IdxW-1:0]            idx_ff, idx_in;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic                       flag_ff, flag_in;
   logic [pbaf_pkg::OpBits-1:0] op_ff, op_in;
   logic                       rflag_ff, rflag_in;
   logic                       err_ff, err_in;
   // size and word walker
   logic [CntW-1:0]            size_ff, size_in;
   logic [QW-1:0]              word_ff, word_in;
   logic [QW-1:0]              limit_ff, limit_in;
   logic [OW-1:0]              off_ff, off_in;
   logic [CntW-1:0]            rem_ff, rem_in;
   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_flag_ff, rsp_flag_in;
   logic                       rsp_err_ff, rsp_err_in;
   logic [CntW-1:0]            rsp_size_ff, rsp_size_in;

   logic [Dw-1:0]        div_x;
   logic [QW-1:0]        div_q;
   logic [OW-1:0]        div_r;
   logic [OW:0]          span;
   logic [Dw-1:0]        upper;
   logic [Dw-1:0]        fill_end;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rsp_free;

   // divider operand select
   always_comb begin
      case (cmd.div_sel)
         pbaf_pkg::DIV_IDX: div_x = Dw'(idx_ff);
         pbaf_pkg::DIV_OLD: div_x = Dw'(size_ff) + Dw'(WORD_BITS - 1);
         pbaf_pkg::DIV_NEW: div_x = Dw'(cnt_ff) + Dw'(WORD_BITS - 1);
         default:           div_x = Dw'(idx_ff);
      endcase
   end

   pbaf_div #(
      .WORD_BITS (WORD_BITS)
   ) u_div (
      .clock    (clock),
      .dividend (div_x),
      .quot     (div_q),
      .rem      (div_r)
   );

   // bit mask of the current word, from the offset and the bits still to go
   always_comb begin
      span  = (OW + 1)'(WORD_BITS) - (OW + 1)'(off_ff);
      upper = Dw'(off_ff) + Dw'(rem_ff);
      for (int i = 0; i < WORD_BITS; i++) begin
         mask[i] = (Dw'(i) >= Dw'(off_ff)) && (Dw'(i) < upper);
      end
   end

   // merged or whole-word write data
   always_comb begin
      if (cmd.wr_grow) begin
         wr_data = {WORD_BITS{flag_ff}};
      end else begin
         wr_data = (rd_data & ~mask) | (flag_ff ? mask : '0);
      end
   end

   pbaf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_fill | cmd.wr_grow),
      .rd_en   (cmd.mem_rd),
      .addr    (AW'(word_ff)),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // item capture and per-item result bits
   always_comb begin
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      flag_in  = flag_ff;
      op_in    = op_ff;
      rflag_in = rflag_ff;
      err_in   = err_ff;
      if (cmd.load) begin
         idx_in   = req_tdata[IdxW-1:0];
         cnt_in   = req_tdata[FlagPos-1:CntLo];
         flag_in  = req_tdata[FlagPos];
         op_in    = req_tuser;
         rflag_in = 1'b0;
         err_in   = 1'b0;
      end
      if (cmd.cap_bit) begin
         rflag_in = rd_data[off_ff];
      end
      if (cmd.set_err) begin
         err_in = 1'b1;
      end
   end

   // size register
   always_comb begin
      size_in = size_ff;
      if (cmd.size_load) begin
         size_in = cnt_ff;
      end else if (cmd.size_clear) begin
         size_in = '0;
      end
   end

   // word walker
   always_comb begin
      word_in  = word_ff;
      limit_in = limit_ff;
      off_in   = off_ff;
      rem_in   = rem_ff;
      if (cmd.seek_load) begin
         word_in = div_q;
         off_in  = div_r;
         rem_in  = cmd.seek_one ? CntW'(1) : cnt_ff;
      end
      if (cmd.base_load) begin
         word_in = div_q;
      end
      if (cmd.limit_load) begin
         limit_in = div_q;
      end
      if (cmd.wr_fill) begin
         word_in = word_ff + QW'(1);
         off_in  = '0;
         rem_in  = rem_ff - CntW'(span);
      end
      if (cmd.wr_grow) begin
         word_in = word_ff + QW'(1);
      end
   end

   // result register, one beat deep
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_size_in  = rsp_size_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_flag_in  = rflag_ff;
         rsp_err_in   = err_ff;
         rsp_size_in  = size_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      flag_ff     <= flag_in;
      op_ff       <= op_in;
      rflag_ff    <= rflag_in;
      err_ff      <= err_in;
      word_ff     <= word_in;
      limit_ff    <= limit_in;
      off_ff      <= off_in;
      rem_ff      <= rem_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_size_ff <= rsp_size_in;
   end

   // status towards the controller
   assign fill_end = Dw'(idx_ff) + Dw'(cnt_ff);

   always_comb begin
      status.opcode     = op_ff;
      status.idx_out    = CntW'(idx_ff) >= size_ff;
      status.fill_out   = fill_end > Dw'(size_ff);
      status.resize_out = 32'(cnt_ff) > 32'(CapBits);
      status.fill_empty = cnt_ff == '0;
      status.mask_full  = (off_ff == '0) && (Dw'(rem_ff) >= Dw'(WORD_BITS));
      status.last_word  = Dw'(rem_ff) <= Dw'(span);
      status.grow_done  = word_ff >= limit_ff;
      status.rsp_free   = rsp_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_size_ff, rsp_flag_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ===== sv/pbaf_ctrl.sv =====
// ---------------------------------------------------------------------------
// pbaf_ctrl
// sequencer for one item at a time: decode, word split, memory walk, result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbaf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pbaf_pkg::status_type status,
   output pbaf_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_DIV2   = 4'd2;
   localparam logic [3:0] S_SEEK   = 4'd3;
   localparam logic [3:0] S_GETRD  = 4'd4;
   localparam logic [3:0] S_GETBIT = 4'd5;
   localparam logic [3:0] S_FILL   = 4'd6;
   localparam logic [3:0] S_FILLWR = 4'd7;
   localparam logic [3:0] S_OLD2   = 4'd8;
   localparam logic [3:0] S_NEW1   = 4'd9;
   localparam logic [3:0] S_NEW2   = 4'd10;
   localparam logic [3:0] S_LIMIT  = 4'd11;
   localparam logic [3:0] S_GROW   = 4'd12;
   localparam logic [3:0] S_FINISH = 4'd13;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = pbaf_pkg::DIV_IDX;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         // range checks; divider stage one takes its operand here
         S_DECODE: begin
            case (status.opcode)
               pbaf_pkg::OP_GET, pbaf_pkg::OP_SET: begin
                  if (status.idx_out) begin
                     cmd.set_err = 1'b1;
                     state_in    = S_FINISH;
                  end else begin
                     state_in = S_DIV2;
                  end
               end
               pbaf_pkg::OP_FILL: begin
                  if (status.fill_out) begin
                     cmd.set_err = 1'b1;
                     state_in    = S_FINISH;
                  end else if (status.fill_empty) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_DIV2;
                  end
               end
               pbaf_pkg::OP_RESIZE: begin
                  cmd.div_sel = pbaf_pkg::DIV_OLD;
                  if (status.resize_out) begin
                     cmd.set_err = 1'b1;
                     state_in    = S_FINISH;
                  end else begin
                     state_in = S_OLD2;
                  end
               end
               pbaf_pkg::OP_CLEAR: begin
                  cmd.size_clear = 1'b1;
                  state_in       = S_FINISH;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_DIV2: begin
            state_in = S_SEEK;
         end
         // load word, offset and bit count of the access
         S_SEEK: begin
            cmd.seek_load = 1'b1;
            cmd.seek_one  = (status.opcode != pbaf_pkg::OP_FILL);
            if (status.opcode == pbaf_pkg::OP_GET) begin
               state_in = S_GETRD;
            end else begin
               state_in = S_FILL;
            end
         end
         S_GETRD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_GETBIT;
         end
         S_GETBIT: begin
            cmd.cap_bit = 1'b1;
            state_in    = S_FINISH;
         end
         // whole words are written at once, partial words read first
         S_FILL: begin
            if (status.mask_full) begin
               cmd.wr_fill = 1'b1;
               if (status.last_word) begin
                  state_in = S_FINISH;
               end
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_FILLWR;
            end
         end
         S_FILLWR: begin
            cmd.wr_fill = 1'b1;
            if (status.last_word) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_FILL;
            end
         end
         S_OLD2: begin
            state_in = S_NEW1;
         end
         S_NEW1: begin
            cmd.base_load = 1'b1;
            cmd.div_sel   = pbaf_pkg::DIV_NEW;
            state_in      = S_NEW2;
         end
         S_NEW2: begin
            state_in = S_LIMIT;
         end
         S_LIMIT: begin
            cmd.limit_load = 1'b1;
            state_in       = S_GROW;
         end
         // one new word per cycle, then the new size
         S_GROW: begin
            if (status.grow_done) begin
               cmd.size_load = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.wr_grow = 1'b1;
            end
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/packed_bit_array_range_fill.sv =====
// ---------------------------------------------------------------------------
// packed_bit_array_range_fill
// flag store packed into words: get, set, fill run, resize and clear
// ---------------------------------------------------------------------------
// One request beat (req_) carries the opcode in tuser and index, count and
// flag in tdata; each request gives exactly one response beat (rsp_) with
// the read bit, the range error flag and the size after the operation.
// Out of range, clear, empty fill and unused opcodes go from decode straight
// to the result; get and set do one memory read, plus the merged write for
// set; fill writes whole words at once and reads partial words first; a
// resize writes each newly used word. req_tready rises together with
// rsp_tvalid. The sequence is set by the single memory port, one word
// per cycle, and the two-stage word/offset divider ahead of every
// memory walk.
// Reset clears the size to zero and the response register; word contents
// stay undefined, no clearing pass is run, and a resize writes every word
// it brings into use. A stalled response holds in its register while the
// next request is worked on; that request then waits until the slot frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_bit_array_range_fill #(
   parameter int WORD_BITS  = 32,
   parameter int WORD_COUNT = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = bit_index[12:0], bit_count[26:13], flag_value[27]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pbaf_pkg::ReqDataBits-1:0] req_tdata,
   // request: tuser = opcode[2:0]
   input  logic [pbaf_pkg::OpBits-1:0]      req_tuser,
   // response: tdata = read_flag[0], current_size[14:1]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pbaf_pkg::RspDataBits-1:0] rsp_tdata,
   // response: tuser = range_error
   output logic                             rsp_tuser
);

   pbaf_pkg::cmd_type    cmd;
   pbaf_pkg::status_type status;

   pbaf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pbaf_dpath #(
      .WORD_BITS  (WORD_BITS),
      .WORD_COUNT (WORD_COUNT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/pbaf_checker.sv =====
// ---------------------------------------------------------------------------
// pbaf_checker
// port-level checks of the flag store, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packed_bit_array_range_fill_macros.svh"

module pbaf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [pbaf_pkg::ReqDataBits-1:0] req_tdata,
   input logic [pbaf_pkg::OpBits-1:0]      req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pbaf_pkg::RspDataBits-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   // a waiting request beat holds still
   `PBAF_ASSERT_NEXT(a_req_hold, req_tvalid && !req_tready, req_tvalid && $stable(req_tdata) && $stable(req_tuser), "request beat changed while waiting")

   // a stalled response beat holds still
   `PBAF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response beat changed while stalled")

   // one item at a time: no request right after an accepted one
   `PBAF_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "request taken while an item is in progress")

   // a refused access never reports a read bit
   `PBAF_ASSERT_IMPL(a_err_no_flag, rsp_tvalid && rsp_tuser, !rsp_tdata[0], "read bit set on a range error")

   // no response beat straight out of reset
   `PBAF_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_tvalid, "response valid after reset")

endmodule

bind packed_bit_array_range_fill pbaf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
